// ----- design/toroidal_blit_address_generator_unit_defines.svh -----
// assertion macros shared by the toroidal blit address generator rtl
// no dependencies; included by the modules that carry assertions
`ifndef TOROIDAL_BLIT_ADDRESS_GENERATOR_UNIT_DEFINES_SVH
`define TOROIDAL_BLIT_ADDRESS_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define TBAG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbag: implication check failed");

// next-cycle implication, off during reset
`define TBAG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbag: next-cycle check failed");

`endif

// ----- design/tbag_pkg.sv -----
// shared constants, types and helpers for the toroidal blit address generator
// no dependencies; imported by every module and interface of the block
package tbag_pkg;

    // largest frame sizes
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;
    localparam int unsigned MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

    // field widths
    localparam int unsigned SIZE_REG_W = 11;
    localparam int unsigned OFF_W      = 16;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned ADDR_W     = 20;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // derived internal widths
    localparam int unsigned SZ_W        = $clog2(MAX_DIM + 1);
    localparam int unsigned POS_W       = $clog2(MAX_DIM);
    localparam int unsigned DIV_W       = OFF_W + 1;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_W);
    localparam int unsigned PROD_W      = POS_W + SZ_W + 1;
    localparam int unsigned ADDR_CALC_W = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH,
        CFG_SRC_HEIGHT,
        CFG_DEST_WIDTH,
        CFG_DEST_HEIGHT,
        CFG_OFFSET_X,
        CFG_OFFSET_Y,
        CFG_CENTRED
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic restart;
        logic run;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic cfg_hit;
    } t_dp_sts;

    // zero reads as one, oversize reads as the maximum
    function automatic logic [SZ_W-1:0] clamp_size(input logic [SIZE_REG_W-1:0] v,
                                                   input int unsigned max_v);
        logic [SZ_W-1:0] res;
        if (v == '0) begin
            res = SZ_W'(1);
        end else if (32'(v) > max_v) begin
            res = SZ_W'(max_v);
        end else begin
            res = SZ_W'(v);
        end
        return res;
    endfunction

endpackage

// ----- design/tbag_intf.sv -----
// valid/ready channel interfaces: pixel in, address word out, register writes
// depends on tbag_pkg for field widths
interface tbag_pix_if import tbag_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface tbag_res_if import tbag_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] dest_address;
    logic [PIX_W-1:0]  pixel_out;
    logic              last;

    modport source (output valid, output dest_address, output pixel_out, output last,
                    input ready);
    modport sink   (input valid, input dest_address, input pixel_out, input last,
                    output ready);
endinterface

interface tbag_cfg_if import tbag_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/tbag_wrap_div.sv -----
// bit-serial remainder lane: wraps a signed start position into 0..size-1
// depends on tbag_pkg; one bit of the dividend per step
module tbag_wrap_div import tbag_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic                    i_step,
    input  logic signed [DIV_W-1:0] i_pos,
    input  logic [SZ_W-1:0]         i_size,
    output logic [POS_W-1:0]        o_wrapped
);

    logic             r_neg;
    logic [DIV_W-1:0] r_dvd;
    logic [SZ_W-1:0]  r_rem;
    logic [DIV_W-1:0] mag;
    logic [SZ_W:0]    trial;
    logic [SZ_W:0]    diff;
    logic [SZ_W-1:0]  n_rem;

    // magnitude of the start position
    assign mag = i_pos[DIV_W-1] ? DIV_W'(-i_pos) : DIV_W'(i_pos);

    // restoring step: shift in the next dividend bit, subtract when it fits
    assign trial = {r_rem, r_dvd[DIV_W-1]};
    assign diff  = trial - {1'b0, i_size};
    assign n_rem = (trial >= {1'b0, i_size}) ? diff[SZ_W-1:0] : trial[SZ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg <= i_pos[DIV_W-1];
            r_dvd <= mag;
            r_rem <= '0;
        end else if (i_step) begin
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    // negative start folds back from the top of the range
    always_comb begin
        if (r_neg && (r_rem != '0)) begin
            o_wrapped = POS_W'(i_size - r_rem);
        end else begin
            o_wrapped = POS_W'(r_rem);
        end
    end

endmodule

// ----- design/tbag_datapath.sv -----
// datapath: register file, wrap lanes, raster counters, address and output word
// depends on tbag_pkg, tbag_intf, tbag_wrap_div and the assertion macro header
`include "toroidal_blit_address_generator_unit_defines.svh"

module tbag_datapath import tbag_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_dp_cmd         i_cmd,
    output t_dp_sts         o_sts,
    tbag_cfg_if.sink        i_cfg,
    tbag_pix_if.sink        i_pix,
    tbag_res_if.source      o_res
);

    // effective register values
    logic [SZ_W-1:0]         r_sw, r_sh, r_dw, r_dh;
    logic signed [OFF_W-1:0] r_off_x, r_off_y;
    logic                    r_centred;

    // raster state
    logic [POS_W-1:0] r_col_cnt, r_row_cnt;
    logic [POS_W-1:0] r_wcol, r_wrow;
    logic [POS_W-1:0] r_base_col, r_base_row;

    // output word
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [PIX_W-1:0]  r_pix;
    logic              r_last;

    logic                    cfg_acc;
    logic                    pix_acc;
    logic signed [DIV_W-1:0] start_col, start_row;
    logic [POS_W-1:0]        wrap_col, wrap_row;
    logic [SZ_W-1:0]         col_inc, row_inc, wcol_inc, wrow_inc;
    logic                    row_end, img_end;
    logic [POS_W-1:0]        wcol_next, wrow_next;
    logic [ADDR_CALC_W-1:0]  addr_full;

    // register writes
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign o_sts.cfg_hit = cfg_acc && (i_cfg.index <= CFG_CENTRED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw      <= SZ_W'(1);
            r_sh      <= SZ_W'(1);
            r_dw      <= SZ_W'(1);
            r_dh      <= SZ_W'(1);
            r_off_x   <= '0;
            r_off_y   <= '0;
            r_centred <= 1'b0;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                CFG_SRC_WIDTH:   r_sw      <= clamp_size(i_cfg.data[SIZE_REG_W-1:0], MAX_WIDTH);
                CFG_SRC_HEIGHT:  r_sh      <= clamp_size(i_cfg.data[SIZE_REG_W-1:0], MAX_HEIGHT);
                CFG_DEST_WIDTH:  r_dw      <= clamp_size(i_cfg.data[SIZE_REG_W-1:0], MAX_WIDTH);
                CFG_DEST_HEIGHT: r_dh      <= clamp_size(i_cfg.data[SIZE_REG_W-1:0], MAX_HEIGHT);
                CFG_OFFSET_X:    r_off_x   <= $signed(i_cfg.data[OFF_W-1:0]);
                CFG_OFFSET_Y:    r_off_y   <= $signed(i_cfg.data[OFF_W-1:0]);
                CFG_CENTRED:     r_centred <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // start positions, pulled back by half the source in centred mode
    assign start_col = DIV_W'(r_off_x) - (r_centred ? DIV_W'(r_sw >> 1) : DIV_W'(0));
    assign start_row = DIV_W'(r_off_y) - (r_centred ? DIV_W'(r_sh >> 1) : DIV_W'(0));

    tbag_wrap_div u_wrap_col (
        .i_clk     (i_clk),
        .i_load    (i_cmd.load),
        .i_step    (i_cmd.step),
        .i_pos     (start_col),
        .i_size    (r_dw),
        .o_wrapped (wrap_col)
    );

    tbag_wrap_div u_wrap_row (
        .i_clk     (i_clk),
        .i_load    (i_cmd.load),
        .i_step    (i_cmd.step),
        .i_pos     (start_row),
        .i_size    (r_dh),
        .o_wrapped (wrap_row)
    );

    // input side: take a pixel while running and the output word is free or leaving
    assign i_pix.ready = i_cmd.run && (!r_out_valid || o_res.ready);
    assign pix_acc     = i_pix.valid && i_pix.ready;

    // raster position and incremental wrap
    assign col_inc  = SZ_W'(r_col_cnt) + SZ_W'(1);
    assign row_inc  = SZ_W'(r_row_cnt) + SZ_W'(1);
    assign row_end  = (col_inc >= r_sw);
    assign img_end  = row_end && (row_inc >= r_sh);
    assign wcol_inc = SZ_W'(r_wcol) + SZ_W'(1);
    assign wrow_inc = SZ_W'(r_wrow) + SZ_W'(1);
    assign wcol_next = (wcol_inc >= r_dw) ? '0 : wcol_inc[POS_W-1:0];
    assign wrow_next = (wrow_inc >= r_dh) ? '0 : wrow_inc[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt  <= '0;
            r_row_cnt  <= '0;
            r_wcol     <= '0;
            r_wrow     <= '0;
            r_base_col <= '0;
            r_base_row <= '0;
        end else if (i_cmd.restart) begin
            r_col_cnt  <= '0;
            r_row_cnt  <= '0;
            r_wcol     <= wrap_col;
            r_wrow     <= wrap_row;
            r_base_col <= wrap_col;
            r_base_row <= wrap_row;
        end else if (pix_acc) begin
            if (img_end) begin
                r_col_cnt <= '0;
                r_row_cnt <= '0;
                r_wcol    <= r_base_col;
                r_wrow    <= r_base_row;
            end else if (row_end) begin
                r_col_cnt <= '0;
                r_row_cnt <= row_inc[POS_W-1:0];
                r_wcol    <= r_base_col;
                r_wrow    <= wrow_next;
            end else begin
                r_col_cnt <= col_inc[POS_W-1:0];
                r_wcol    <= wcol_next;
            end
        end
    end

    // linear address: row times destination width plus column
    assign addr_full = ADDR_CALC_W'(r_wrow) * ADDR_CALC_W'(r_dw) + ADDR_CALC_W'(r_wcol);

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pix_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_addr <= addr_full[ADDR_W-1:0];
            r_pix  <= i_pix.pixel;
            r_last <= img_end;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.dest_address = r_addr;
    assign o_res.pixel_out    = r_pix;
    assign o_res.last         = r_last;

    // checks
    `TBAG_ASSERT_NXT(a_take_fills_out, i_clk, i_rst_n, pix_acc, r_out_valid)
    `TBAG_ASSERT_IMP(a_col_in_src, i_clk, i_rst_n, i_cmd.run, SZ_W'(r_col_cnt) < r_sw)
    `TBAG_ASSERT_IMP(a_col_in_dest, i_clk, i_rst_n, i_cmd.run, SZ_W'(r_wcol) < r_dw)

endmodule

// ----- design/tbag_ctrl.sv -----
// controller: sequences the wrap lanes after a register write, then lets pixels run
// depends on tbag_pkg and the assertion macro header
`include "toroidal_blit_address_generator_unit_defines.svh"

module tbag_ctrl import tbag_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_READY,
        ST_LOAD,
        ST_WRAP,
        ST_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    t_dp_cmd              r_cmd, n_cmd;

    // next state; any valid register write restarts the wrap
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        if (i_sts.cfg_hit) begin
            n_state = ST_LOAD;
        end else begin
            case (r_state)
                ST_READY: n_state = ST_READY;
                ST_LOAD: begin
                    n_state = ST_WRAP;
                    n_cnt   = DIV_CNT_W'(DIV_W - 1);
                end
                ST_WRAP: begin
                    if (r_cnt == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_cnt = r_cnt - DIV_CNT_W'(1);
                    end
                end
                ST_DONE: n_state = ST_READY;
                default: n_state = ST_READY;
            endcase
        end
        n_cmd.load    = (n_state == ST_LOAD);
        n_cmd.step    = (n_state == ST_WRAP);
        n_cmd.restart = (n_state == ST_DONE);
        n_cmd.run     = (n_state == ST_READY);
    end

    // state and registered commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_READY;
            r_cnt   <= '0;
            r_cmd   <= '{load: 1'b0, step: 1'b0, restart: 1'b0, run: 1'b1};
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cmd   <= n_cmd;
        end
    end

    assign o_cmd = r_cmd;

    // checks
    `TBAG_ASSERT_NXT(a_write_reloads, i_clk, i_rst_n, i_sts.cfg_hit, r_state == ST_LOAD)
    `TBAG_ASSERT_NXT(a_wrap_ends, i_clk, i_rst_n, (r_state == ST_WRAP) && (r_cnt == '0) && !i_sts.cfg_hit, r_cmd.restart)
    `TBAG_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot(r_cmd))

endmodule

// ----- design/toroidal_blit_address_generator_unit.sv -----
// top level of the toroidal blit address generator: controller plus datapath
// depends on tbag_pkg, tbag_intf, tbag_ctrl and tbag_datapath
//
//   channel  dir  modport  word
//   i_cfg    in   sink     register index, write data
//   i_pix    in   sink     source pixel, raster order
//   o_res    out  source   destination address, pixel, last flag
//
// one pixel per cycle while unstalled; the output word register frees itself as it is taken
// a valid register write blocks pixels through load, 17 steps of the
// bit-serial remainder lanes that wrap the start column and row, and restart
// synchronous reset gives unit sizes, zero offsets and an origin at address zero
// a stalled output holds its word; the next pixel is taken in the cycle it leaves
module toroidal_blit_address_generator_unit import tbag_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbag_cfg_if.sink   i_cfg,
    tbag_pix_if.sink   i_pix,
    tbag_res_if.source o_res
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    tbag_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // counters, wrap lanes and output word
    tbag_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_cfg   (i_cfg),
        .i_pix   (i_pix),
        .o_res   (o_res)
    );

endmodule

// ----- tb/sv/toroidal_blit_address_generator_unit_test.sv -----
// self-checking bench for the toroidal blit address generator: directed rows, then random images
// depends on tbag_pkg and the tbag channel interfaces; drives dut over its three channels
module toroidal_blit_address_generator_unit_test import tbag_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int          IDLE_PCT      = 16;
    localparam int          RANDOM_PIXELS = 500;
    localparam int          QUIET_LO      = 250;
    localparam int          QUIET_HI      = 350;
    localparam int          HOLD_AT       = 120;
    localparam int          HOLD_LEN      = 80;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          NUM_DIRECTED  = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // one addressed pixel write as it leaves the block
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic              last;
    } blit_word_t;

    // directed row: a register write or a pixel, optionally with a typed-in word
    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pixel;
        logic                  known;
        blit_word_t            want;
    } blit_row_t;

    localparam blit_row_t DIRECTED [NUM_DIRECTED] = '{
        // unit sizes after reset: every pixel lands on address zero and ends the image
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'h00, 1'b1, '{20'd0, 8'h00, 1'b1}},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'hFF, 1'b1, '{20'd0, 8'hFF, 1'b1}},
        // 3x2 image, centred, negative offsets, junk above the size bits
        '{1'b1, CFG_SRC_WIDTH,   16'h0003, 8'h00, 1'b0, '0},
        '{1'b1, CFG_SRC_HEIGHT,  16'h0002, 8'h00, 1'b0, '0},
        '{1'b1, CFG_DEST_WIDTH,  16'hF804, 8'h00, 1'b0, '0},
        '{1'b1, CFG_DEST_HEIGHT, 16'h0003, 8'h00, 1'b0, '0},
        '{1'b1, CFG_OFFSET_X,    16'hFFFF, 8'h00, 1'b0, '0},
        '{1'b1, CFG_OFFSET_Y,    16'h8000, 8'h00, 1'b0, '0},
        '{1'b1, CFG_CENTRED,     16'h0001, 8'h00, 1'b0, '0},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'h01, 1'b0, '0},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'h80, 1'b0, '0},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'h55, 1'b0, '0},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'hAA, 1'b0, '0},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'h7F, 1'b0, '0},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'hFE, 1'b0, '0},
        // write to the unused index leaves the image running
        '{1'b1, CFG_UNUSED_IDX,  16'hFFFF, 8'h00, 1'b0, '0},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'h3C, 1'b0, '0},
        // zero width reads as one, oversize width as the maximum, largest positive offset
        '{1'b1, CFG_SRC_WIDTH,   16'h0000, 8'h00, 1'b0, '0},
        '{1'b1, CFG_DEST_WIDTH,  16'h07FF, 8'h00, 1'b0, '0},
        '{1'b1, CFG_OFFSET_X,    16'h7FFF, 8'h00, 1'b0, '0},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'hC3, 1'b1, '{20'd1023, 8'hC3, 1'b0}},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'h5A, 1'b1, '{20'd2047, 8'h5A, 1'b1}},
        // centred flag taken from bit zero only
        '{1'b1, CFG_CENTRED,     16'hFFFE, 8'h00, 1'b0, '0},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'h0F, 1'b0, '0},
        '{1'b0, CFG_UNUSED_IDX,  16'h0000, 8'hF0, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    tbag_cfg_if cfg_ch ();
    tbag_pix_if pix_ch ();
    tbag_res_if res_ch ();

    toroidal_blit_address_generator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    // register copies and image counters of the address predictor
    logic [SIZE_REG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [OFF_W-1:0]      off_x_reg, off_y_reg;
    logic                  centred_reg;
    int unsigned           col_cnt, row_cnt, cur_col, cur_row, org_col, org_row;

    blit_word_t pending_writes [$];
    int         pixels_sent  = 0;
    int         words_taken  = 0;
    int         mismatches   = 0;
    int         cycle_count  = 0;
    bit         writing_regs = 1'b0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // zero reads as one, oversize as the maximum
    function automatic int unsigned fit_size(logic [SIZE_REG_W-1:0] v, int unsigned max_v);
        if (v == '0) return 1;
        if (32'(v) > max_v) return max_v;
        return 32'(v);
    endfunction

    // true remainder of the signed start position, centred if asked
    function automatic int unsigned wrapped_origin(logic [OFF_W-1:0] off, int unsigned src_sz,
                                                   int unsigned dst_sz);
        int pos;
        int rem;
        pos = int'($signed(off));
        if (centred_reg) pos -= int'(src_sz / 2);
        rem = pos % int'(dst_sz);
        if (rem < 0) rem += int'(dst_sz);
        return rem;
    endfunction

    task automatic restart_image();
        org_col = wrapped_origin(off_x_reg, fit_size(src_w_reg, MAX_WIDTH),
                                 fit_size(dst_w_reg, MAX_WIDTH));
        org_row = wrapped_origin(off_y_reg, fit_size(src_h_reg, MAX_HEIGHT),
                                 fit_size(dst_h_reg, MAX_HEIGHT));
        col_cnt = 0;
        row_cnt = 0;
        cur_col = org_col;
        cur_row = org_row;
    endtask

    // register write as the block sees it; any valid index restarts the image
    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SRC_WIDTH:   src_w_reg = data[SIZE_REG_W-1:0];
            CFG_SRC_HEIGHT:  src_h_reg = data[SIZE_REG_W-1:0];
            CFG_DEST_WIDTH:  dst_w_reg = data[SIZE_REG_W-1:0];
            CFG_DEST_HEIGHT: dst_h_reg = data[SIZE_REG_W-1:0];
            CFG_OFFSET_X:    off_x_reg = data[OFF_W-1:0];
            CFG_OFFSET_Y:    off_y_reg = data[OFF_W-1:0];
            CFG_CENTRED:     centred_reg = data[0];
            default:         return;
        endcase
        restart_image();
    endtask

    // destination address of the next source pixel, then step the raster
    task automatic predict_write(input logic [PIX_W-1:0] p, output blit_word_t w);
        int unsigned sw, sh, dw, dh;
        bit          row_end, img_end;
        sw = fit_size(src_w_reg, MAX_WIDTH);
        sh = fit_size(src_h_reg, MAX_HEIGHT);
        dw = fit_size(dst_w_reg, MAX_WIDTH);
        dh = fit_size(dst_h_reg, MAX_HEIGHT);
        row_end = (col_cnt + 1 >= sw);
        img_end = row_end && (row_cnt + 1 >= sh);
        w.addr = ADDR_W'(cur_row * dw + cur_col);
        w.pix  = p;
        w.last = img_end;
        if (img_end) begin
            col_cnt = 0;
            row_cnt = 0;
            cur_col = org_col;
            cur_row = org_row;
        end else if (row_end) begin
            col_cnt = 0;
            row_cnt++;
            cur_col = org_col;
            cur_row = (cur_row + 1 >= dh) ? 0 : cur_row + 1;
        end else begin
            col_cnt++;
            cur_col = (cur_col + 1 >= dw) ? 0 : cur_col + 1;
        end
    endtask

    // register write, only once every pending word has come out
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        if (!writing_regs) begin
            pix_ch.valid <= 1'b0;
            while (pending_writes.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            writing_regs = 1'b1;
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg(idx, data);
    endtask

    // offer one pixel, with random gaps outside the quiet stretch
    task automatic send_pixel(input logic [PIX_W-1:0] p, input bit known, input blit_word_t typed);
        blit_word_t w;
        if (writing_regs) begin
            cfg_ch.valid <= 1'b0;
            writing_regs = 1'b0;
        end
        while (!(pixels_sent >= QUIET_LO && pixels_sent < QUIET_HI) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= p;
        do @(posedge i_clk); while (!pix_ch.ready);
        predict_write(p, w);
        pending_writes.push_back(known ? typed : w);
        pixels_sent++;
    endtask

    // size word: source sides mostly small, junk in the bits above the field
    function automatic logic [CFG_DATA_W-1:0] size_word(bit src_side);
        logic [SIZE_REG_W-1:0] v;
        int                    pick;
        pick = $urandom_range(0, 19);
        if (src_side && pick < 12) begin
            v = SIZE_REG_W'($urandom_range(1, 6));
        end else begin
            case (pick % 6)
                0:       v = '0;
                1:       v = SIZE_REG_W'(MAX_DIM);
                2:       v = '1;
                3:       v = SIZE_REG_W'($urandom_range(MAX_DIM + 1, 2047));
                4:       v = SIZE_REG_W'($urandom_range(1, 8));
                default: v = SIZE_REG_W'($urandom_range(1, MAX_DIM));
            endcase
        end
        return {5'($urandom), v};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] offset_word();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // result side: random stalls, one long hold-off while pixels are offered
    initial begin
        blit_word_t want;
        int         hold_left;
        bit         hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (pending_writes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: addr %0d pix %02h last %0b",
                                 res_ch.dest_address, res_ch.pixel_out, res_ch.last);
                end else begin
                    want = pending_writes.pop_front();
                    if (res_ch.dest_address !== want.addr || res_ch.pixel_out !== want.pix ||
                        res_ch.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: want addr %0d pix %02h last %0b, got addr %0d pix %02h last %0b",
                                     words_taken, want.addr, want.pix, want.last,
                                     res_ch.dest_address, res_ch.pixel_out, res_ch.last);
                    end
                end
                words_taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (!hold_done && words_taken >= HOLD_AT && pix_ch.valid) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                res_ch.ready <= 1'b0;
            end else if (words_taken >= QUIET_LO && words_taken < QUIET_HI) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // stimulus: reset, directed rows, random images, drain
    initial begin
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] word;
        int unsigned           img;
        int unsigned           count;
        int                    rand_start;
        bit                    first_phase;
        i_rst_n      <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // predictor reset state
        src_w_reg   = 11'd1;
        src_h_reg   = 11'd1;
        dst_w_reg   = 11'd1;
        dst_h_reg   = 11'd1;
        off_x_reg   = '0;
        off_y_reg   = '0;
        centred_reg = 1'b0;
        restart_image();

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (DIRECTED[i].is_write)
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            else
                send_pixel(DIRECTED[i].pixel, DIRECTED[i].known, DIRECTED[i].want);
        end

        // random phases: a few register writes, then random pixels, mostly whole images if small
        first_phase = 1'b1;
        rand_start  = pixels_sent;
        while (pixels_sent - rand_start < RANDOM_PIXELS) begin
            for (int r = 0; r < (1 << CFG_IDX_W); r++) begin
                idx = CFG_IDX_W'(r);
                if (idx == CFG_UNUSED_IDX) begin
                    if ($urandom_range(0, 9) == 0) write_reg(idx, 16'($urandom));
                end else if (first_phase || $urandom_range(0, 1) == 1) begin
                    case (idx)
                        CFG_SRC_WIDTH, CFG_SRC_HEIGHT:   word = size_word(1'b1);
                        CFG_DEST_WIDTH, CFG_DEST_HEIGHT: word = size_word(1'b0);
                        CFG_OFFSET_X, CFG_OFFSET_Y:      word = offset_word();
                        default:                         word = 16'($urandom);
                    endcase
                    write_reg(idx, word);
                end
            end
            first_phase = 1'b0;
            img = fit_size(src_w_reg, MAX_WIDTH) * fit_size(src_h_reg, MAX_HEIGHT);
            if (img <= 48) begin
                count = img * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) count += $urandom_range(0, img - 1);
            end else begin
                count = $urandom_range(1, 40);
            end
            repeat (count) send_pixel(8'($urandom), 1'b0, '0);
        end

        // drain
        if (writing_regs) cfg_ch.valid <= 1'b0;
        pix_ch.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_writes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- toroidal_blit_address_generator_unit.f -----
+incdir+design
design/tbag_pkg.sv
design/tbag_intf.sv
design/tbag_wrap_div.sv
design/tbag_datapath.sv
design/tbag_ctrl.sv
design/toroidal_blit_address_generator_unit.sv
tb/sv/toroidal_blit_address_generator_unit_test.sv
